### rtl/core/apb_pkg.sv
// ----------------------------------------------------------------------------
// apb_pkg
// Shared types, operation codes and arithmetic helpers for the ARGB8888
// pixel blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package apb_pkg;

  // Operation codes carried on tuser.
  localparam logic [2:0] KIND_BLEND_SRC = 3'd0;
  localparam logic [2:0] KIND_BLEND_AMT = 3'd1;
  localparam logic [2:0] KIND_DARKEN    = 3'd2;
  localparam logic [2:0] KIND_DESAT     = 3'd3;
  localparam logic [2:0] KIND_FADE      = 3'd4;
  localparam logic [2:0] KIND_PREMUL    = 3'd5;

  localparam int unsigned NUM_CH = 3;

  // Fixed-point reciprocal of 100: 5243 / 2^19.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // One accepted input word.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] dest;
    logic [31:0] src;
    logic [7:0]  amount;
    logic [6:0]  pct;
  } apb_item_t;

  // Products after the multiply stage.
  typedef struct packed {
    logic [2:0]                  kind;
    logic [31:0]                 dest;
    logic [31:0]                 src;
    logic [7:0]                  amount;
    logic                        pct_zero;
    logic                        pct_full;
    logic [NUM_CH-1:0][15:0]     mul_inv;
    logic [NUM_CH-1:0][15:0]     mul_src;
    logic [NUM_CH-1:0][14:0]     fade_mag;
    logic [NUM_CH-1:0]           fade_neg;
    logic [7:0]                  gray;
  } apb_prod_t;

  // Scaled channels after the divide stage.
  typedef struct packed {
    logic [2:0]                  kind;
    logic [31:0]                 dest;
    logic [31:0]                 src;
    logic [7:0]                  amount;
    logic                        pct_zero;
    logic                        pct_full;
    logic [NUM_CH-1:0][7:0]      scl_inv;
    logic [NUM_CH-1:0][7:0]      scl_src;
    logic [NUM_CH-1:0][7:0]      fade_q;
    logic [NUM_CH-1:0]           fade_neg;
    logic [7:0]                  gray;
  } apb_scl_t;

  // Rounded division of an 8x8 product by 255: round(p / 255).
  // With x = p + 127 < 2^16, x / 255 equals (x + (x >> 8) + 1) >> 8.
  function automatic logic [7:0] div255_round(input logic [15:0] prod);
    logic [16:0] x;
    logic [16:0] t;
    begin
      x = {1'b0, prod} + 17'd127;
      t = x + {8'd0, x[16:8]} + 17'd1;
      return t[15:8];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/apb_mul_stage.sv
// ----------------------------------------------------------------------------
// apb_mul_stage
// First pipeline stage: per-channel 8x8 products for blending and scaling,
// signed fade products, and the desaturation gray level.
// ----------------------------------------------------------------------------
`default_nettype none

module apb_mul_stage (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  apb_pkg::apb_item_t     in_item,
  output logic                   out_valid,
  input  wire                    out_ready,
  output apb_pkg::apb_prod_t     out_prod
);
  import apb_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  apb_prod_t  prod_r;
  apb_prod_t  prod_nxt;

  logic [7:0] a_sel;
  logic [7:0] a_inv;
  logic [7:0] r_ch;
  logic [7:0] g_ch;
  logic [7:0] b_ch;
  logic [7:0] mx;
  logic [7:0] mn;
  logic [8:0] mm_sum;

  // Stage advances when empty or when the next stage takes its word.
  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Blend factor: source alpha for kind 0, the amount field otherwise.
  assign a_sel = (in_item.kind == KIND_BLEND_SRC) ? in_item.src[31:24] : in_item.amount;
  assign a_inv = ALPHA_OPAQUE - a_sel;

  // Max and min of the source color channels for desaturation.
  assign r_ch = in_item.src[23:16];
  assign g_ch = in_item.src[15:8];
  assign b_ch = in_item.src[7:0];

  always_comb begin
    mx = r_ch;
    mn = r_ch;
    if (g_ch > mx) begin
      mx = g_ch;
    end
    if (b_ch > mx) begin
      mx = b_ch;
    end
    if (g_ch < mn) begin
      mn = g_ch;
    end
    if (b_ch < mn) begin
      mn = b_ch;
    end
  end

  assign mm_sum = {1'b0, mx} + {1'b0, mn};

  // Per-channel products.
  always_comb begin
    logic [7:0]         d_ch;
    logic [7:0]         s_ch;
    logic signed [8:0]  diff;
    logic signed [16:0] fprod;
    logic [16:0]        fabs;
    prod_nxt.kind     = in_item.kind;
    prod_nxt.dest     = in_item.dest;
    prod_nxt.src      = in_item.src;
    prod_nxt.amount   = in_item.amount;
    prod_nxt.pct_zero = (in_item.pct == 7'd0);
    prod_nxt.pct_full = (in_item.pct >= PCT_FULL);
    prod_nxt.gray     = mm_sum[8:1];
    for (int c = 0; c < NUM_CH; c++) begin
      d_ch  = in_item.dest[c*8 +: 8];
      s_ch  = in_item.src[c*8 +: 8];
      prod_nxt.mul_inv[c] = {8'd0, d_ch} * {8'd0, a_inv};
      prod_nxt.mul_src[c] = {8'd0, s_ch} * {8'd0, a_sel};
      diff  = $signed({1'b0, s_ch}) - $signed({1'b0, d_ch});
      fprod = 17'(diff) * $signed({10'd0, in_item.pct});
      fabs  = fprod[16] ? 17'(-fprod) : 17'(fprod);
      prod_nxt.fade_mag[c] = fabs[14:0];
      prod_nxt.fade_neg[c] = fprod[16];
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

`default_nettype wire

### rtl/core/apb_scale_stage.sv
// ----------------------------------------------------------------------------
// apb_scale_stage
// Second pipeline stage: rounded division by 255 of the scaling products and
// reciprocal-multiply division by 100 of the fade magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module apb_scale_stage (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  apb_pkg::apb_prod_t     in_prod,
  output logic                   out_valid,
  input  wire                    out_ready,
  output apb_pkg::apb_scl_t      out_scl
);
  import apb_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  apb_scl_t  scl_r;
  apb_scl_t  scl_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Scale and divide each channel.
  always_comb begin
    logic [27:0] fq;
    scl_nxt.kind     = in_prod.kind;
    scl_nxt.dest     = in_prod.dest;
    scl_nxt.src      = in_prod.src;
    scl_nxt.amount   = in_prod.amount;
    scl_nxt.pct_zero = in_prod.pct_zero;
    scl_nxt.pct_full = in_prod.pct_full;
    scl_nxt.fade_neg = in_prod.fade_neg;
    scl_nxt.gray     = in_prod.gray;
    for (int c = 0; c < NUM_CH; c++) begin
      scl_nxt.scl_inv[c] = div255_round(in_prod.mul_inv[c]);
      scl_nxt.scl_src[c] = div255_round(in_prod.mul_src[c]);
      // Quotient of the magnitude by 100, exact for magnitudes below 25600, whose quotient fits in 8 bits.
      fq = {13'd0, in_prod.fade_mag[c]} * {15'd0, RECIP_100};
      scl_nxt.fade_q[c] = fq[RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      scl_r <= scl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_scl   = scl_r;

endmodule

`default_nettype wire

### rtl/core/apb_merge_stage.sv
// ----------------------------------------------------------------------------
// apb_merge_stage
// Final pipeline stage: sums blend terms, applies the signed fade step,
// selects the result by operation and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apb_merge_stage (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  apb_pkg::apb_scl_t      in_scl,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [31:0]            out_pixel
);
  import apb_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] pixel_r;
  logic [31:0] pixel_nxt;

  logic [23:0] blend_rgb;
  logic [23:0] fade_rgb;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Blend sums and fade steps per channel, both wrapping at 8 bits.
  always_comb begin
    logic [7:0] step;
    for (int c = 0; c < NUM_CH; c++) begin
      blend_rgb[c*8 +: 8] = in_scl.scl_inv[c] + in_scl.scl_src[c];
      step = in_scl.fade_neg[c] ? 8'(-in_scl.fade_q[c]) : in_scl.fade_q[c];
      fade_rgb[c*8 +: 8] = in_scl.dest[c*8 +: 8] + step;
    end
  end

  // Result selection by operation.
  always_comb begin
    case (in_scl.kind)
      KIND_BLEND_SRC, KIND_BLEND_AMT: begin
        pixel_nxt = {ALPHA_OPAQUE, blend_rgb};
      end
      KIND_DARKEN: begin
        pixel_nxt = {ALPHA_OPAQUE, in_scl.scl_src};
      end
      KIND_DESAT: begin
        pixel_nxt = {in_scl.src[31:24], in_scl.gray, in_scl.gray, in_scl.gray};
      end
      KIND_FADE: begin
        if (in_scl.pct_zero) begin
          pixel_nxt = in_scl.dest;
        end else if (in_scl.pct_full) begin
          pixel_nxt = in_scl.src;
        end else begin
          pixel_nxt = {ALPHA_OPAQUE, fade_rgb};
        end
      end
      KIND_PREMUL: begin
        if (in_scl.amount == 8'd0) begin
          pixel_nxt = 32'd0;
        end else if (in_scl.amount == ALPHA_OPAQUE) begin
          pixel_nxt = {ALPHA_OPAQUE, in_scl.src[23:0]};
        end else begin
          pixel_nxt = {in_scl.amount, in_scl.scl_src};
        end
      end
      default: begin
        pixel_nxt = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

endmodule

`default_nettype wire

### rtl/core/argb_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// argb_pixel_blend_unit
// Streaming ARGB8888 pixel operations: alpha blend, darken, desaturate,
// percent fade and premultiply, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) carries one word per pixel: the operation code
//   on in_tuser and the two pixels, amount and fade percent on in_tdata.
//   The output channel (out_*) returns one packed ARGB8888 pixel per input
//   word, in order.
//   From acceptance to out_tvalid a word passes a multiply stage, a
//   divide stage (rounding by 255, reciprocal for 100) and a merge stage
//   that owns the output register.
//   Throughput is one word per cycle while out_tready stays high; no state links one word to the next.
//   Synchronous reset clears all valid bits; no word is pending afterward.
//   When the receiver holds out_tready low, the output word and out_tvalid
//   hold and the stall propagates backward stage by stage; in_tready stays
//   high as long as some stage still has a free slot, and nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module argb_pixel_blend_unit (
  input  wire         clk,
  input  wire         rst_n,
  // Input channel.
  input  wire         in_tvalid,
  output logic        in_tready,
  // in_tdata: dest_pixel [31:0], src_pixel [63:32], amount [71:64],
  //           fade_percent [78:72], zero fill [79].
  input  wire [79:0]  in_tdata,
  // in_tuser: kind [2:0].
  input  wire [2:0]   in_tuser,
  // Output channel.
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_tdata: result_pixel [31:0].
  output logic [31:0] out_tdata
);
  import apb_pkg::*;

  apb_item_t item;
  apb_prod_t prod;
  apb_scl_t  scl;
  logic      prod_valid;
  logic      prod_ready;
  logic      scl_valid;
  logic      scl_ready;

  // Unpack the input word.
  assign item.kind   = in_tuser;
  assign item.dest   = in_tdata[31:0];
  assign item.src    = in_tdata[63:32];
  assign item.amount = in_tdata[71:64];
  assign item.pct    = in_tdata[78:72];

  apb_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  apb_scale_stage u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_scl   (scl)
  );

  apb_merge_stage u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_scl    (scl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/core/apb_checker.sv
// ----------------------------------------------------------------------------
// apb_checker
// Port-level checks for the pixel blend unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module apb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata
);

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // With the output register free to move, the pipeline takes a new word.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output can drain");

  // Without stalls an accepted word passes the multiply, scale and merge registers and appears on the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_tvalid && in_tready, 3) && $past(out_tready, 1) && $past(out_tready, 2)
      && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) |-> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind argb_pixel_blend_unit apb_checker u_apb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/sv/apb_blend_checker.sv
// ----------------------------------------------------------------------------
// apb_blend_checker
// Watches both stream channels of the ARGB8888 pixel blend unit, computes
// the expected result pixel for every accepted input word and compares it
// with the words that leave the unit, in order.
// ----------------------------------------------------------------------------
module apb_blend_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  // in_tdata: dest_pixel [31:0], src_pixel [63:32], amount [71:64],
  //           fade_percent [78:72], zero fill [79].
  input  wire [79:0]  in_tdata,
  // in_tuser: kind [2:0].
  input  wire [2:0]   in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  // out_tdata: result_pixel [31:0].
  input  wire [31:0]  out_tdata,
  output int          mismatch_count,
  output int          pending_words
);

  import apb_pkg::*;

  // Result pixels still owed by the unit, oldest first.
  logic [31:0] expected_pixels [$];

  // Rounded scaling of one channel: round(v * a / 255).
  function automatic logic [7:0] scale_channel(input logic [7:0] v, input logic [7:0] a);
    int unsigned q;
    q = (int'(v) * int'(a) + 127) / 255;
    return q[7:0];
  endfunction

  // Mix of two pixels by a weight; the alpha of the result is opaque.
  function automatic logic [31:0] mix_pixels(input logic [31:0] d, input logic [31:0] s,
                                             input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    inv = ALPHA_OPAQUE - a;
    r = scale_channel(d[23:16], inv) + scale_channel(s[23:16], a);
    g = scale_channel(d[15:8], inv) + scale_channel(s[15:8], a);
    b = scale_channel(d[7:0], inv) + scale_channel(s[7:0], a);
    return {ALPHA_OPAQUE, r, g, b};
  endfunction

  // One channel of a percent fade; the division truncates toward zero.
  function automatic logic [7:0] fade_channel(input logic [7:0] from_v, input logic [7:0] to_v,
                                              input logic [6:0] pct);
    int diff;
    int v;
    diff = int'(to_v) - int'(from_v);
    v = int'(from_v) + (diff * int'(pct)) / 100;
    return v[7:0];
  endfunction

  // Result pixel for one input word.
  function automatic logic [31:0] composite_pixel(input logic [2:0] kind,
                                                  input logic [31:0] d, input logic [31:0] s,
                                                  input logic [7:0] amt, input logic [6:0] pct);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [8:0] sum;
    logic [31:0] res;
    res = '0;
    case (kind)
      KIND_BLEND_SRC: begin
        res = mix_pixels(d, s, s[31:24]);
      end
      KIND_BLEND_AMT: begin
        res = mix_pixels(d, s, amt);
      end
      KIND_DARKEN: begin
        res = {ALPHA_OPAQUE, scale_channel(s[23:16], amt), scale_channel(s[15:8], amt),
               scale_channel(s[7:0], amt)};
      end
      KIND_DESAT: begin
        hi = s[23:16];
        lo = s[23:16];
        if (s[15:8] > hi) hi = s[15:8];
        if (s[7:0] > hi) hi = s[7:0];
        if (s[15:8] < lo) lo = s[15:8];
        if (s[7:0] < lo) lo = s[7:0];
        sum = {1'b0, hi} + {1'b0, lo};
        res = {s[31:24], sum[8:1], sum[8:1], sum[8:1]};
      end
      KIND_FADE: begin
        if (pct == 7'd0) begin
          res = d;
        end else if (pct >= PCT_FULL) begin
          res = s;
        end else begin
          res = {ALPHA_OPAQUE, fade_channel(d[23:16], s[23:16], pct),
                 fade_channel(d[15:8], s[15:8], pct), fade_channel(d[7:0], s[7:0], pct)};
        end
      end
      KIND_PREMUL: begin
        if (amt == 8'd0) begin
          res = '0;
        end else if (amt == ALPHA_OPAQUE) begin
          res = {ALPHA_OPAQUE, s[23:0]};
        end else begin
          res = {amt, scale_channel(s[23:16], amt), scale_channel(s[15:8], amt),
                 scale_channel(s[7:0], amt)};
        end
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  // Retire results first, then record the word accepted at the same edge.
  always @(posedge clk) begin : watch
    logic [31:0] want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_pixels.delete();
      mismatch_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result_pixel: no word expected, actual %h", out_tdata);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata !== want) begin
            $error("result_pixel: expected %h, actual %h", want, out_tdata);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(composite_pixel(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                                  in_tdata[71:64], in_tdata[78:72]));
      end
      mismatch_count <= mismatch_count + errs;
    end
    pending_words <= expected_pixels.size();
  end

endmodule

### tb/sv/tb_argb_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_argb_pixel_blend_unit
// Drives directed and random pixel words into the blend unit with random
// gaps on the input and random and long stalls on the output, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_argb_pixel_blend_unit;

  import apb_pkg::*;

  // Operation codes the unit leaves unused; they must yield a zero pixel.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_WORDS = 600;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  int mismatch_count;
  int pending_words;
  int cycle_count;
  bit sender_steady;

  argb_pixel_blend_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  apb_blend_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Runaway guard.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[argb_pixel_blend_unit] ERROR");
      $finish;
    end
  end

  // Offer one word, after random idle cycles unless sender_steady is set, and hold it until taken.
  task automatic send_word(input logic [2:0] kind, input logic [31:0] dest_px,
                           input logic [31:0] src_px, input logic [7:0] amt,
                           input logic [6:0] pct);
    while (!sender_steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, pct, amt, src_px, dest_px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Receiver: random stalls, two long hold-offs and one stretch that never stalls.
  initial begin : result_sink
    int cycle_no;
    int hold_left;
    cycle_no = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no == 300 || cycle_no == 900) hold_left = 160;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (cycle_no >= 550 && cycle_no < 750) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [2:0]  kind;
    logic [31:0] dest_px;
    logic [31:0] src_px;
    logic [7:0]  amt;
    logic [6:0]  pct;
    sender_steady = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: extremes of each operation and its special cases.
    send_word(KIND_BLEND_SRC, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 7'd0);
    send_word(KIND_BLEND_SRC, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 7'd127);
    send_word(KIND_BLEND_SRC, 32'h1234_5678, 32'h80C0_3F01, 8'h55, 7'd42);
    send_word(KIND_BLEND_AMT, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 7'd0);
    send_word(KIND_BLEND_AMT, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 7'd0);
    send_word(KIND_BLEND_AMT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h80, 7'd0);
    send_word(KIND_DARKEN, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 7'd0);
    send_word(KIND_DARKEN, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 7'd0);
    send_word(KIND_DARKEN, 32'hFFFF_FFFF, 32'h00FF_8001, 8'h7F, 7'd0);
    send_word(KIND_DESAT, 32'h0000_0000, 32'hFF10_2030, 8'h00, 7'd0);
    send_word(KIND_DESAT, 32'hFFFF_FFFF, 32'h7F00_FF00, 8'hFF, 7'd0);
    send_word(KIND_FADE, 32'h1122_3344, 32'hFFFF_FFFF, 8'h00, 7'd0);
    send_word(KIND_FADE, 32'h1122_3344, 32'h5566_7788, 8'h00, 7'd100);
    send_word(KIND_FADE, 32'h1122_3344, 32'h0000_0000, 8'h00, 7'd127);
    send_word(KIND_FADE, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 7'd50);
    send_word(KIND_FADE, 32'h0010_2030, 32'hFF00_00FF, 8'h00, 7'd99);
    send_word(KIND_FADE, 32'h00FF_00FF, 32'hFF00_FF00, 8'h00, 7'd1);
    send_word(KIND_PREMUL, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 7'd0);
    send_word(KIND_PREMUL, 32'h0000_0000, 32'h0012_3456, 8'hFF, 7'd0);
    send_word(KIND_PREMUL, 32'h0000_0000, 32'hFFFF_FFFF, 8'h80, 7'd0);
    send_word(KIND_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 7'd127);
    send_word(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 7'd127);

    // Random words, weighted toward the edges of amount, alpha and percent.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sender_steady = (n >= 250 && n < 350);
      if ($urandom_range(0, 99) < 4) begin
        kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else begin
        kind = 3'($urandom_range(0, 5));
      end
      dest_px = $urandom;
      src_px  = $urandom;
      case ($urandom_range(0, 7))
        0: src_px[31:24] = 8'h00;
        1: src_px[31:24] = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: amt = 8'h00;
        1: amt = 8'hFF;
        2: amt = 8'h01;
        3: amt = 8'hFE;
        default: amt = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 7))
        0: pct = 7'd0;
        1: pct = 7'($urandom_range(100, 127));
        2: pct = 7'd99;
        3: pct = 7'd1;
        default: pct = 7'($urandom_range(0, 127));
      endcase
      send_word(kind, dest_px, src_px, amt, pct);
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker see the last word, then wait for every result.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[argb_pixel_blend_unit] OK");
    end else begin
      $display("[argb_pixel_blend_unit] ERROR");
    end
    $finish;
  end

endmodule
